>>> src/uart_pwm_pkg.sv
// uart_pwm_pkg: shared types and constants of the serial command pwm block
// result item layout, register map and register reset values
// no dependencies
package uart_pwm_pkg;

  // register map, index times four gives the byte address
  typedef enum logic [2:0] {
    REG_HALF_BIT = 3'd0,
    REG_BIT      = 3'd1,
    REG_OFF_CODE = 3'd2,
    REG_ON_CODE  = 3'd3,
    REG_OFF_DUTY = 3'd4,
    REG_ON_DUTY  = 3'd5,
    REG_PWM_TOP  = 3'd6,
    REG_PRESCALE = 3'd7
  } reg_idx_e;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // register reset values
  localparam logic [15:0] HalfBitRst  = 16'd52;
  localparam logic [15:0] BitRst      = 16'd104;
  localparam logic [7:0]  OffCodeRst  = 8'd97;
  localparam logic [7:0]  OnCodeRst   = 8'd98;
  localparam logic [7:0]  OffDutyRst  = 8'd0;
  localparam logic [7:0]  OnDutyRst   = 8'd255;
  localparam logic [7:0]  PwmTopRst   = 8'd255;
  localparam logic [8:0]  PrescaleRst = 9'd8;

  // one result item
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       led_level;
    logic [7:0] duty_now;
  } result_t;

endpackage

>>> src/uart_rx_command_pwm.sv
// uart_rx_command_pwm: 8n1-style serial receiver decoding command bytes into a pwm duty
// depends on uart_pwm_pkg; apb-style register port, valid/stall item channels
// results are registered; a skid register behind the output register absorbs one stall
// throughput: one item per cycle, input stalled while the skid register is full
// reset: asynchronous active low, registers to their reset values, receiver idle, line high
module uart_rx_command_pwm #(
  parameter int unsigned DATA_BITS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [uart_pwm_pkg::AddrW-1:0]  paddr,
  input  logic [uart_pwm_pkg::DataW-1:0]  pwdata,
  output logic [uart_pwm_pkg::DataW-1:0]  prdata,
  output logic                            pready,
  // input items
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            rx_level_i,
  // result items
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            byte_valid_o,
  output logic [7:0]                      byte_value_o,
  output logic                            led_level_o,
  output logic [7:0]                      duty_now_o
);
  import uart_pwm_pkg::*;

  // receiver phase codes
  localparam logic [1:0] PhIdle  = 2'd0;
  localparam logic [1:0] PhStart = 2'd1;
  localparam logic [1:0] PhData  = 2'd2;

  localparam logic [3:0] DataBitsC = 4'(DATA_BITS);

  // configuration registers
  logic [15:0] half_bit_q, bit_q;
  logic [7:0]  off_code_q, on_code_q, off_duty_q, on_duty_q, pwm_top_q;
  logic [8:0]  prescale_q;

  // block state
  logic [1:0]  phase_q, phase_d;
  logic        prev_q;
  logic [15:0] tick_q, tick_d;
  logic [3:0]  bits_q, bits_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  duty_q, duty_d;
  logic [7:0]  pwm_q, pwm_d;
  logic [8:0]  pre_q, pre_d;

  // output register and skid register
  logic    out_v_q, skid_v_q;
  result_t out_q, skid_q, res_d;

  logic accept, take, cfg_wr;
  logic done;
  logic [15:0] tick_inc, half_min, bit_min;
  logic [3:0]  bits_inc;
  logic [8:0]  pre_inc, pre_min;

  assign accept = in_valid_i && !skid_v_q;
  assign take   = out_v_q && !out_stall_i;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_bit_q <= HalfBitRst;
      bit_q      <= BitRst;
      off_code_q <= OffCodeRst;
      on_code_q  <= OnCodeRst;
      off_duty_q <= OffDutyRst;
      on_duty_q  <= OnDutyRst;
      pwm_top_q  <= PwmTopRst;
      prescale_q <= PrescaleRst;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[4:2]))
        REG_HALF_BIT: half_bit_q <= pwdata[15:0];
        REG_BIT:      bit_q      <= pwdata[15:0];
        REG_OFF_CODE: off_code_q <= pwdata[7:0];
        REG_ON_CODE:  on_code_q  <= pwdata[7:0];
        REG_OFF_DUTY: off_duty_q <= pwdata[7:0];
        REG_ON_DUTY:  on_duty_q  <= pwdata[7:0];
        REG_PWM_TOP:  pwm_top_q  <= pwdata[7:0];
        REG_PRESCALE: prescale_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    prdata = '0;
    unique case (reg_idx_e'(paddr[4:2]))
      REG_HALF_BIT: prdata = {16'd0, half_bit_q};
      REG_BIT:      prdata = {16'd0, bit_q};
      REG_OFF_CODE: prdata = {24'd0, off_code_q};
      REG_ON_CODE:  prdata = {24'd0, on_code_q};
      REG_OFF_DUTY: prdata = {24'd0, off_duty_q};
      REG_ON_DUTY:  prdata = {24'd0, on_duty_q};
      REG_PWM_TOP:  prdata = {24'd0, pwm_top_q};
      REG_PRESCALE: prdata = {23'd0, prescale_q};
      default:      prdata = '0;
    endcase
  end

  // zero intervals act as one
  assign half_min = (half_bit_q == 16'd0) ? 16'd1 : half_bit_q;
  assign bit_min  = (bit_q == 16'd0) ? 16'd1 : bit_q;
  assign pre_min  = (prescale_q == 9'd0) ? 9'd1 : prescale_q;
  assign tick_inc = tick_q + 16'd1;
  assign bits_inc = bits_q + 4'd1;
  assign pre_inc  = pre_q + 9'd1;

  // receiver, command decode and pwm for one item
  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bits_d  = bits_q;
    shift_d = shift_q;
    duty_d  = duty_q;
    done    = 1'b0;
    unique case (phase_q)
      PhIdle: begin
        if (prev_q && !rx_level_i) begin
          phase_d = PhStart;
          tick_d  = '0;
        end
      end
      PhStart: begin
        tick_d = tick_inc;
        if (tick_inc >= half_min) begin
          phase_d = PhData;
          tick_d  = '0;
          bits_d  = '0;
          shift_d = '0;
        end
      end
      PhData: begin
        tick_d = tick_inc;
        if (tick_inc >= bit_min) begin
          tick_d = '0;
          if (!bits_q[3]) begin
            shift_d = shift_q | (8'(rx_level_i) << bits_q[2:0]);
          end
          bits_d = bits_inc;
          if (bits_inc >= DataBitsC) begin
            done    = 1'b1;
            phase_d = PhIdle;
            bits_d  = '0;
            if (shift_d == off_code_q) begin
              duty_d = off_duty_q;
            end else if (shift_d == on_code_q) begin
              duty_d = on_duty_q;
            end
          end
        end
      end
      default: phase_d = PhIdle;
    endcase

    // pwm counter, led uses the count before this advance
    pre_d = pre_inc;
    pwm_d = pwm_q;
    if (pre_inc >= pre_min) begin
      pre_d = '0;
      pwm_d = (pwm_q >= pwm_top_q) ? 8'd0 : pwm_q + 8'd1;
    end

    res_d.byte_valid = done;
    res_d.byte_value = done ? shift_d : 8'd0;
    res_d.led_level  = (pwm_q < duty_d) || (duty_d == pwm_top_q);
    res_d.duty_now   = duty_d;
  end

  // state update on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      prev_q  <= 1'b1;
      tick_q  <= '0;
      bits_q  <= '0;
      shift_q <= '0;
      duty_q  <= '0;
      pwm_q   <= '0;
      pre_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      prev_q  <= rx_level_i;
      tick_q  <= tick_d;
      bits_q  <= bits_d;
      shift_q <= shift_d;
      duty_q  <= duty_d;
      pwm_q   <= pwm_d;
      pre_q   <= pre_d;
    end
  end

  // output and skid valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (take) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= accept;
      end
    end else if (accept) begin
      if (out_v_q) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end
  end

  // output and skid payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res_d;
      end
    end else if (accept) begin
      if (out_v_q) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign in_stall_o   = skid_v_q;
  assign out_valid_o  = out_v_q;
  assign byte_valid_o = out_q.byte_valid;
  assign byte_value_o = out_q.byte_value;
  assign led_level_o  = out_q.led_level;
  assign duty_now_o   = out_q.duty_now;

  // checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid register full while output register empty");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && done) |=> (phase_q == PhIdle)) else $error("receiver not idle after byte");

  a_duty_only_on_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && done) |=> $stable(duty_q)) else $error("duty changed without a byte");

  a_bits_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q < DataBitsC) else $error("bit count beyond frame length");

  a_zero_byte_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_q.byte_valid) |-> (out_q.byte_value == 8'd0))
    else $error("byte value set without a byte");

endmodule

>>> test/testbench.sv
// testbench: self-checking bench for the serial command receiver with pwm led driver
// drives sampled line items and register writes, predicts every result item and compares them
// depends on uart_pwm_pkg and uart_rx_command_pwm
`timescale 1ns / 100ps

module testbench;
  import uart_pwm_pkg::*;

  localparam int unsigned DataBits   = 8;
  localparam int unsigned HoldCycles = 60;

  typedef enum logic [1:0] {
    RX_IDLE  = 2'd0,
    RX_START = 2'd1,
    RX_DATA  = 2'd2
  } rx_phase_e;

  // block ports, all inputs known from time zero
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             psel        = 1'b0;
  logic             penable     = 1'b0;
  logic             pwrite      = 1'b0;
  logic [AddrW-1:0] paddr       = '0;
  logic [DataW-1:0] pwdata      = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic             rx_level_i  = 1'b1;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             byte_valid_o;
  logic [7:0]       byte_value_o;
  logic             led_level_o;
  logic [7:0]       duty_now_o;

  // register copies, reset values
  logic [15:0] cfg_half     = HalfBitRst;
  logic [15:0] cfg_bit      = BitRst;
  logic [7:0]  cfg_off_code = OffCodeRst;
  logic [7:0]  cfg_on_code  = OnCodeRst;
  logic [7:0]  cfg_off_duty = OffDutyRst;
  logic [7:0]  cfg_on_duty  = OnDutyRst;
  logic [7:0]  cfg_top      = PwmTopRst;
  logic [8:0]  cfg_prescale = PrescaleRst;

  // receiver and pwm state of the prediction
  rx_phase_e   line_phase = RX_IDLE;
  logic        last_level = 1'b1;
  logic [15:0] tick_cnt   = '0;
  logic [3:0]  bit_cnt    = '0;
  logic [7:0]  shreg      = '0;
  logic [7:0]  duty       = '0;
  logic [7:0]  pwm_cnt    = '0;
  logic [8:0]  pre_cnt    = '0;

  result_t     tick_results_q[$];
  int unsigned mismatch_cnt  = 0;
  int unsigned ticks_sent    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned holds_asked   = 0;
  int unsigned holds_done    = 0;

  uart_rx_command_pwm #(
    .DATA_BITS(DataBits)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_level_i  (rx_level_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .byte_valid_o(byte_valid_o),
    .byte_value_o(byte_value_o),
    .led_level_o (led_level_o),
    .duty_now_o  (duty_now_o)
  );

  initial begin : clock_gen
    forever #6 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #1_200_000;
    $display("FAIL uart_rx_command_pwm");
    $finish;
  end

  // zero interval behaves as one
  function automatic logic [15:0] at_least1(input logic [15:0] v);
    return (v == '0) ? 16'd1 : v;
  endfunction

  // one tick of the receiver and pwm counter, returns the outputs of that tick
  function automatic result_t step_receiver(input logic level);
    result_t r;
    r = '0;
    case (line_phase)
      RX_IDLE: begin
        if (last_level && !level) begin
          line_phase = RX_START;
          tick_cnt   = '0;
        end
      end
      RX_START: begin
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= at_least1(cfg_half)) begin
          line_phase = RX_DATA;
          tick_cnt   = '0;
          bit_cnt    = '0;
          shreg      = '0;
        end
      end
      RX_DATA: begin
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= at_least1(cfg_bit)) begin
          tick_cnt = '0;
          if (bit_cnt < 4'd8) shreg = shreg | (8'(level) << bit_cnt);
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt >= DataBits) begin
            r.byte_valid = 1'b1;
            r.byte_value = shreg;
            line_phase   = RX_IDLE;
            bit_cnt      = '0;
            // off code wins when both codes match
            if (shreg == cfg_off_code) duty = cfg_off_duty;
            else if (shreg == cfg_on_code) duty = cfg_on_duty;
          end
        end
      end
      default: line_phase = RX_IDLE;
    endcase
    last_level = level;
    // led from the counter before this tick's advance
    r.led_level = (pwm_cnt < duty) || (duty == cfg_top);
    pre_cnt = pre_cnt + 9'd1;
    if (pre_cnt >= at_least1(16'(cfg_prescale))) begin
      pre_cnt = '0;
      pwm_cnt = (pwm_cnt >= cfg_top) ? 8'd0 : pwm_cnt + 8'd1;
    end
    r.duty_now = duty;
    return r;
  endfunction

  function automatic void note_mismatch(input string what, input int unsigned want,
                                        input int unsigned got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endfunction

  // compare each accepted result, predict each accepted item
  always @(posedge clk_i) begin : scoreboard
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (tick_results_q.size() == 0) begin
          note_mismatch("result with nothing pending", 0, 1);
        end else begin
          want = tick_results_q.pop_front();
          if (byte_valid_o !== want.byte_valid)
            note_mismatch("byte_valid", 32'(want.byte_valid), 32'(byte_valid_o));
          if (byte_value_o !== want.byte_value)
            note_mismatch("byte_value", 32'(want.byte_value), 32'(byte_value_o));
          if (led_level_o !== want.led_level)
            note_mismatch("led_level", 32'(want.led_level), 32'(led_level_o));
          if (duty_now_o !== want.duty_now)
            note_mismatch("duty_now", 32'(want.duty_now), 32'(duty_now_o));
        end
      end
      if (in_valid_i && !in_stall_o) tick_results_q.push_back(step_receiver(rx_level_i));
    end
  end

  // result side stalls, with a long hold-off when one is asked for
  initial begin : result_stall
    forever begin
      @(posedge clk_i);
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    stall_pct    <= recv_pct;
  endtask

  // offer one line sample and wait until it is taken
  task automatic send_item(input logic level);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_level_i <= level;
    do @(posedge clk_i); while (in_stall_o);
    ticks_sent++;
  endtask

  // stop offering and wait until every predicted item has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tick_results_q.size() != 0);
  endtask

  // setup and access cycle, junk above the register width
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    logic [31:0] junk;
    logic [31:0] mask;
    logic [31:0] word;
    int unsigned field_w;
    junk = $urandom();
    case (idx)
      REG_HALF_BIT, REG_BIT: field_w = 16;
      REG_PRESCALE:          field_w = 9;
      default:               field_w = 8;
    endcase
    mask = (32'd1 << field_w) - 32'd1;
    word = (junk & ~mask) | (value & mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_HALF_BIT: cfg_half     = word[15:0];
      REG_BIT:      cfg_bit      = word[15:0];
      REG_OFF_CODE: cfg_off_code = word[7:0];
      REG_ON_CODE:  cfg_on_code  = word[7:0];
      REG_OFF_DUTY: cfg_off_duty = word[7:0];
      REG_ON_DUTY:  cfg_on_duty  = word[7:0];
      REG_PWM_TOP:  cfg_top      = word[7:0];
      default:      cfg_prescale = word[8:0];
    endcase
    @(posedge clk_i);
  endtask

  // start bit, eight data bits first bit first, stop level, optional line glitches
  task automatic send_frame(input logic [7:0] data, input int unsigned lead,
                            input logic stop_level, input int unsigned flip_pct);
    int unsigned bit_len;
    logic [9:0]  frame;
    bit_len = 32'(at_least1(cfg_bit));
    frame   = {stop_level, data, 1'b0};
    repeat (lead) send_item(1'b1);
    for (int i = 0; i < 10; i++)
      repeat (bit_len) send_item(frame[i] ^ ($urandom_range(99) < flip_pct));
  endtask

  // mostly clean command frames, some with low stop, glitches or pure noise
  task automatic run_traffic(input int unsigned n_ticks);
    int unsigned stop_at;
    int unsigned pick;
    logic [7:0]  data;
    stop_at = ticks_sent + n_ticks;
    while (ticks_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 35) data = cfg_off_code;
      else if (pick < 70) data = cfg_on_code;
      else data = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 70) send_frame(data, $urandom_range(1, 3), 1'b1, 0);
      else if (pick < 80) send_frame(data, $urandom_range(1, 3), 1'b0, 0);
      else if (pick < 90) send_frame(data, $urandom_range(1, 3), 1'b1, 8);
      else repeat ($urandom_range(2, 12)) send_item(1'($urandom_range(1)));
    end
  endtask

  // new random setting of every register, then traffic
  task automatic run_phase(input int unsigned bit_len, input int unsigned n_ticks);
    logic [7:0] top;
    logic [7:0] code;
    wait_idle();
    case ($urandom_range(9))
      0:       top = 8'd0;
      1, 2:    top = 8'd255;
      3:       top = 8'd1;
      default: top = 8'($urandom_range(2, 254));
    endcase
    write_reg(REG_BIT, bit_len);
    write_reg(REG_HALF_BIT, ($urandom_range(4) == 0) ? $urandom_range(bit_len + 1)
                                                     : (bit_len + 1) / 2);
    code = 8'($urandom_range(255));
    write_reg(REG_OFF_CODE, 32'(code));
    write_reg(REG_ON_CODE, ($urandom_range(9) == 0) ? 32'(code) : $urandom_range(255));
    case ($urandom_range(2))
      0:       write_reg(REG_OFF_DUTY, 0);
      1:       write_reg(REG_OFF_DUTY, 32'(top));
      default: write_reg(REG_OFF_DUTY, $urandom_range(255));
    endcase
    case ($urandom_range(2))
      0:       write_reg(REG_ON_DUTY, 255);
      1:       write_reg(REG_ON_DUTY, 32'(top));
      default: write_reg(REG_ON_DUTY, $urandom_range(255));
    endcase
    write_reg(REG_PWM_TOP, 32'(top));
    case ($urandom_range(9))
      0:       write_reg(REG_PRESCALE, 0);
      1:       write_reg(REG_PRESCALE, 256);
      2:       write_reg(REG_PRESCALE, 511);
      default: write_reg(REG_PRESCALE, $urandom_range(1, 3));
    endcase
    run_traffic(n_ticks);
  endtask

  // reset values, zero intervals, zero top, equal codes, duty above top, line low after a frame
  task automatic test_directed_frames();
    repeat (3) send_item(1'b1);
    wait_idle();
    write_reg(REG_HALF_BIT, 0);
    write_reg(REG_BIT, 0);
    write_reg(REG_PRESCALE, 0);
    write_reg(REG_PWM_TOP, 0);
    write_reg(REG_OFF_CODE, 32'hFF);
    write_reg(REG_ON_CODE, 32'hFF);
    write_reg(REG_OFF_DUTY, 32'h80);
    write_reg(REG_ON_DUTY, 32'h7F);
    send_frame(8'hFF, 1, 1'b1, 0);
    send_frame(8'h00, 1, 1'b0, 0);
    repeat (2) send_item(1'b0);
    send_item(1'b1);
  endtask

  // widest intervals and the remaining register extremes
  task automatic test_register_extremes();
    wait_idle();
    write_reg(REG_HALF_BIT, 32'hFFFF);
    write_reg(REG_BIT, 32'hFFFF);
    write_reg(REG_PRESCALE, 256);
    write_reg(REG_PWM_TOP, 255);
    write_reg(REG_OFF_CODE, 0);
    write_reg(REG_ON_CODE, 255);
    write_reg(REG_OFF_DUTY, 255);
    write_reg(REG_ON_DUTY, 0);
    repeat (4) send_item(1'b1);
    repeat (8) send_item(1'b0);
    repeat (8) send_item(1'($urandom_range(1)));
  endtask

  // command traffic under each idling pattern
  task automatic test_command_traffic();
    set_idling(24, 52);
    run_phase(4, 100);
    run_phase(2, 90);
    set_idling(52, 24);
    run_phase(3, 90);
    run_phase(6, 100);
    set_idling(0, 0);
    run_phase(1, 80);
    run_phase(5, 100);
  endtask

  // long hold-off on the result side while items keep coming
  task automatic test_backpressure();
    wait_idle();
    write_reg(REG_BIT, 2);
    write_reg(REG_HALF_BIT, 1);
    holds_asked <= holds_asked + 1;
    run_traffic(40);
  endtask

  initial begin : run_tests
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_idling(24, 52);
    test_directed_frames();
    test_register_extremes();
    test_command_traffic();
    test_backpressure();
    wait_idle();
    repeat (16) @(posedge clk_i);
    if (mismatch_cnt == 0 && tick_results_q.size() == 0) begin
      $display("PASS uart_rx_command_pwm");
    end else begin
      $display("FAIL uart_rx_command_pwm");
    end
    $finish;
  end

endmodule
